/* sv/hbl_pkg.sv */
// ---------------------------------------------------------------------------
// hbl_pkg
// Shared types and constants of the histogram localizer.
// ---------------------------------------------------------------------------
package hbl_pkg;

  localparam logic [16:0] PROB_ONE  = 17'd65536;
  localparam logic [15:0] SCALE_ONE = 16'd256;

  localparam logic [2:0] REG_MAP        = 3'd0;
  localparam logic [2:0] REG_CELLS      = 3'd1;
  localparam logic [2:0] REG_MOVE_WALL  = 3'd2;
  localparam logic [2:0] REG_MOVE_DOOR  = 3'd3;
  localparam logic [2:0] REG_SCALE_WALL = 3'd4;
  localparam logic [2:0] REG_SCALE_DOOR = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNI_WAIT,
    ST_P_GETPREV,
    ST_P_MUL1,
    ST_P_MUL2,
    ST_P_MUL3,
    ST_N_RD,
    ST_N_START,
    ST_N_WAIT,
    ST_E_RD,
    ST_E_LD
  } state_t;

  typedef struct packed {
    logic uni_start;
    logic uni_load;
    logic step_init;
    logic p_getprev;
    logic p_mul1;
    logic p_mul2;
    logic p_mul3;
    logic n_rd;
    logic n_start;
    logic n_write;
    logic e_rd;
    logic e_load;
  } cmd_t;

  typedef struct packed {
    logic last_cell;
    logic div_done;
    logic degen;
    logic out_free;
  } sts_t;

endpackage

/* sv/hbl_ram.sv */
// ---------------------------------------------------------------------------
// hbl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module hbl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/hbl_divider.sv */
// ---------------------------------------------------------------------------
// hbl_divider
// Restoring divider, one quotient bit per cycle; quotient known to fit QW bits.
// ---------------------------------------------------------------------------
module hbl_divider #(
  parameter int NW = 43,
  parameter int DW = 32,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_q;
  logic [QW-1:0] nlo;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem, nlo[QW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        if (cnt == CW'(QW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= DW'(num[NW-1:QW]);
      nlo   <= num[QW-1:0];
      den_q <= den;
      quot  <= '0;
    end else if (run) begin
      rem  <= ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      nlo  <= {nlo[QW-2:0], 1'b0};
      quot <= {quot[QW-2:0], ge};
    end
  end

endmodule

/* sv/hbl_ctrl.sv */
// ---------------------------------------------------------------------------
// hbl_ctrl
// Sequencer for restart, prediction, normalization and emit passes.
// ---------------------------------------------------------------------------
module hbl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_command,
  output logic          in_ready,
  input  hbl_pkg::sts_t sts,
  output hbl_pkg::cmd_t cmd
);

  import hbl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command) begin
            cmd.step_init = 1'b1;
            state_next    = ST_P_GETPREV;
          end else begin
            cmd.uni_start = 1'b1;
            state_next    = ST_UNI_WAIT;
          end
        end
      end
      ST_UNI_WAIT: begin
        if (sts.div_done) begin
          cmd.uni_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_P_GETPREV: begin
        cmd.p_getprev = 1'b1;
        state_next    = ST_P_MUL1;
      end
      ST_P_MUL1: begin
        cmd.p_mul1 = 1'b1;
        state_next = ST_P_MUL2;
      end
      ST_P_MUL2: begin
        cmd.p_mul2 = 1'b1;
        state_next = ST_P_MUL3;
      end
      ST_P_MUL3: begin
        cmd.p_mul3 = 1'b1;
        state_next = sts.last_cell ? ST_N_RD : ST_P_MUL1;
      end
      ST_N_RD: begin
        cmd.n_rd   = 1'b1;
        state_next = ST_N_START;
      end
      ST_N_START: begin
        cmd.n_start = 1'b1;
        state_next  = ST_N_WAIT;
      end
      ST_N_WAIT: begin
        if (sts.degen || sts.div_done) begin
          cmd.n_write = 1'b1;
          state_next  = sts.last_cell ? ST_E_RD : ST_N_RD;
        end
      end
      ST_E_RD: begin
        cmd.e_rd   = 1'b1;
        state_next = ST_E_LD;
      end
      ST_E_LD: begin
        if (sts.out_free) begin
          cmd.e_load = 1'b1;
          state_next = sts.last_cell ? ST_IDLE : ST_E_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");
  a_uni_ret: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UNI_WAIT && sts.div_done) |=> state == ST_IDLE)
    else $error("restart did not return to idle");
  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_E_LD && sts.out_free && sts.last_cell) |=> state == ST_IDLE)
    else $error("emit pass did not end on last cell");

endmodule

/* sv/hbl_datapath.sv */
// ---------------------------------------------------------------------------
// hbl_datapath
// Config registers, belief and weight memories, multiply, sum and divide.
// ---------------------------------------------------------------------------
module hbl_datapath #(
  parameter int MAX_CELLS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  hbl_pkg::cmd_t cmd,
  output hbl_pkg::sts_t sts,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          in_reading,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [4:0]    out_cell,
  output logic [16:0]   out_belief,
  output logic          out_likely,
  output logic          out_degen,
  output logic          out_last
);

  import hbl_pkg::*;

  localparam int IW  = $clog2(MAX_CELLS);
  localparam int BW  = FRAC_BITS + 1;
  localparam int AW  = FRAC_BITS + 18;
  localparam int PW  = FRAC_BITS + 2;
  localparam int WW  = PW + 8;
  localparam int SW  = WW + $clog2(MAX_CELLS + 1);
  localparam int NW  = WW + FRAC_BITS + 1;
  localparam logic [BW-1:0] ONE = BW'(1) << FRAC_BITS;
  localparam int RESET_N = (MAX_CELLS < 10) ? MAX_CELLS : 10;
  localparam logic [BW-1:0] U_RESET = BW'(((1 << FRAC_BITS) + RESET_N / 2) / RESET_N);
  localparam logic [BW-1:0] TOL = BW'(((1 << FRAC_BITS) + 50) / 100);

  logic [31:0] corridor_map;
  logic [5:0]  corridor_cells;
  logic [16:0] move_success_wall;
  logic [16:0] move_success_door;
  logic [15:0] match_scale_wall;
  logic [15:0] match_scale_door;

  logic [BW-1:0]        u_val;
  logic [MAX_CELLS-1:0] valid;
  logic                 rvalid_q;
  logic                 reading;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        prev_idx;
  logic [BW-1:0]        bprev;
  logic [BW-1:0]        bcur;
  logic [AW-1:0]        acc;
  logic [SW-1:0]        sum;
  logic [BW-1:0]        maxb;

  logic [6:0]    n_full;
  logic [IW-1:0] nm1;
  logic          last_cell;

  always_comb begin
    if (corridor_cells == 6'd0) begin
      n_full = 7'd1;
    end else if (7'(corridor_cells) > 7'(MAX_CELLS)) begin
      n_full = 7'(MAX_CELLS);
    end else begin
      n_full = 7'(corridor_cells);
    end
  end
  assign nm1       = IW'(n_full - 7'd1);
  assign last_cell = idx == nm1;

  function automatic logic door_of(input logic [IW-1:0] c, input logic [31:0] map);
    int unsigned k;
    k = int'(c);
    return (k < 32) ? map[k[4:0]] : 1'b0;
  endfunction

  function automatic logic [16:0] succ_of(input logic d, input logic [16:0] sw,
                                          input logic [16:0] sd);
    logic [16:0] s;
    s = d ? sd : sw;
    return (s > PROB_ONE) ? PROB_ONE : s;
  endfunction

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      corridor_map      <= 32'd212;
      corridor_cells    <= 6'd10;
      move_success_wall <= 17'd58982;
      move_success_door <= 17'd58982;
      match_scale_wall  <= 16'd1024;
      match_scale_door  <= 16'd1024;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAP:        corridor_map      <= cfg_data;
        REG_CELLS:      corridor_cells    <= cfg_data[5:0];
        REG_MOVE_WALL:  move_success_wall <= cfg_data[16:0];
        REG_MOVE_DOOR:  move_success_door <= cfg_data[16:0];
        REG_SCALE_WALL: match_scale_wall  <= cfg_data[15:0];
        REG_SCALE_DOOR: match_scale_door  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // belief memory
  logic          b_re;
  logic [IW-1:0] b_raddr;
  logic [BW-1:0] b_rdata;
  logic [BW-1:0] bval;
  logic [BW-1:0] q_val;
  logic [BW-1:0] div_q;
  logic          div_done;

  always_comb begin
    b_re    = cmd.step_init | cmd.p_getprev | (cmd.p_mul3 & ~last_cell) | cmd.e_rd;
    b_raddr = idx;
    if (cmd.step_init) begin
      b_raddr = nm1;
    end else if (cmd.p_mul3) begin
      b_raddr = idx + 1'b1;
    end
  end

  assign q_val = sts.degen ? '0 : div_q;

  hbl_ram #(.WIDTH(BW), .DEPTH(MAX_CELLS)) u_bram (
    .clk   (clk),
    .we    (cmd.n_write),
    .waddr (idx),
    .wdata (q_val),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign bval = rvalid_q ? b_rdata : u_val;

  // prediction and weighting
  logic          door_prev;
  logic          door_cur;
  logic [16:0]   s_prev;
  logic [16:0]   fail_cur;
  logic [PW-1:0] pred;
  logic [15:0]   lik;
  logic [WW-1:0] wval;
  logic [WW-1:0] w_rdata;

  assign door_prev = door_of(prev_idx, corridor_map);
  assign door_cur  = door_of(idx, corridor_map);
  assign s_prev    = succ_of(door_prev, move_success_wall, move_success_door);
  assign fail_cur  = PROB_ONE - succ_of(door_cur, move_success_wall, move_success_door);
  assign pred      = PW'((acc + AW'(32768)) >> 16);
  assign lik       = (door_cur == reading) ?
                     (door_cur ? match_scale_door : match_scale_wall) : SCALE_ONE;
  assign wval      = WW'(((PW + 16)'(pred) * (PW + 16)'(lik) + (PW + 16)'(128)) >> 8);

  hbl_ram #(.WIDTH(WW), .DEPTH(MAX_CELLS)) u_wram (
    .clk   (clk),
    .we    (cmd.p_mul3),
    .waddr (idx),
    .wdata (wval),
    .re    (cmd.n_rd),
    .raddr (idx),
    .rdata (w_rdata)
  );

  // shared divider
  logic          div_start;
  logic [NW-1:0] div_num;
  logic [SW-1:0] div_den;

  assign div_start = cmd.uni_start | (cmd.n_start & ~sts.degen);
  always_comb begin
    if (cmd.uni_start) begin
      div_num = NW'(ONE) + NW'(n_full >> 1);
      div_den = SW'(n_full);
    end else begin
      div_num = (NW'(w_rdata) << FRAC_BITS) + NW'(sum >> 1);
      div_den = sum;
    end
  end

  hbl_divider #(.NW(NW), .DW(SW), .QW(BW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      u_val     <= U_RESET;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.uni_load) begin
        u_val <= div_q;
        valid <= '0;
      end else if (cmd.n_write) begin
        valid[idx] <= 1'b1;
      end
      if (cmd.e_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_re) begin
      rvalid_q <= valid[b_raddr];
    end
    if (cmd.step_init) begin
      reading  <= in_reading;
      sum      <= '0;
      maxb     <= '0;
      idx      <= '0;
      prev_idx <= nm1;
    end
    if (cmd.p_getprev) begin
      bprev <= bval;
    end
    if (cmd.p_mul1) begin
      bcur <= bval;
      acc  <= AW'(bprev) * AW'(s_prev);
    end
    if (cmd.p_mul2) begin
      acc <= acc + AW'(bcur) * AW'(fail_cur);
    end
    if (cmd.p_mul3) begin
      sum      <= sum + SW'(wval);
      bprev    <= bcur;
      prev_idx <= idx;
    end
    if (cmd.n_write && q_val > maxb) begin
      maxb <= q_val;
    end
    if (cmd.e_load) begin
      out_cell   <= 5'(idx);
      out_belief <= 17'(bval);
      out_likely <= (BW + 1)'(bval) + (BW + 1)'(TOL) >= (BW + 1)'(maxb);
      out_degen  <= sts.degen;
      out_last   <= last_cell;
    end
    if (cmd.p_mul3 || cmd.n_write || cmd.e_load) begin
      idx <= last_cell ? '0 : idx + 1'b1;
    end
  end

  assign sts.last_cell = last_cell;
  assign sts.div_done  = div_done;
  assign sts.degen     = sum == '0;
  assign sts.out_free  = ~out_valid | out_ready;

endmodule

/* sv/histogram_bayes_localizer.sv */
// ---------------------------------------------------------------------------
// histogram_bayes_localizer
// Discrete Bayes histogram filter over a cyclic corridor of walls and doors.
// ---------------------------------------------------------------------------
// One item at a time. A restart beat runs the serial divider that forms the
// uniform belief. A step beat with n cells first fetches the wrapped
// neighbor, then runs the prediction multiply steps P_MUL1, P_MUL2 and
// P_MUL3 for each cell, a bit-serial normalizing divide per cell (skipped
// when the sum is zero), and a read-out that emits one result beat per cell,
// waiting while the output is stalled. Beliefs are unsigned Q1.16 at the
// default FRAC_BITS of 16.
module histogram_bayes_localizer #(
  parameter int MAX_CELLS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // reading_is_door
  input  logic [0:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // cell_index, belief, likely, degenerate
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  import hbl_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [4:0]  out_cell;
  logic [16:0] out_belief;
  logic        out_likely;
  logic        out_degen;

  assign cfg_ready = 1'b1;

  hbl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_command (s_axis_tuser[0]),
    .in_ready   (s_axis_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  hbl_datapath #(.MAX_CELLS(MAX_CELLS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_reading (s_axis_tdata[0]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_cell   (out_cell),
    .out_belief (out_belief),
    .out_likely (out_likely),
    .out_degen  (out_degen),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_degen, out_likely, out_belief, out_cell};

endmodule
